// ===== rtl/srhm_pkg.sv =====
package srhm_pkg;

  localparam int unsigned NumRegs         = 8;
  localparam int unsigned DefaultChannels = 8;
  localparam int unsigned ChanW           = 3;
  localparam int unsigned DataW           = 32;
  localparam int unsigned CfgIdxW         = 3;

  localparam logic [DataW-1:0] ThrReset = '1;

  typedef struct packed {
    logic [ChanW-1:0]        channel;
    logic signed [DataW-1:0] sample;
    logic                    sample_good;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0]        out_channel;
    logic signed [DataW-1:0] merged_value;
    logic                    merged_good;
    logic                    spike_rejected;
  } out_item_t;

endpackage

// ===== rtl/srhm_thr_regs.sv =====
module srhm_thr_regs
  import srhm_pkg::*;
#(
  parameter int unsigned CHANNELS = DefaultChannels
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  wr_en_i,
  input  logic [CfgIdxW-1:0]                    wr_idx_i,
  input  logic [DataW-1:0]                      wr_data_i,
  input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] rd_idx_i,
  output logic [DataW-1:0]                      thr_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [DataW-1:0] thr_q [CHANNELS];
  logic             wr_in_range;

  // writes to registers of channels that are not built are dropped
  assign wr_in_range = ({1'b0, wr_idx_i} < (CfgIdxW + 1)'(CHANNELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        thr_q[i] <= ThrReset;
      end
    end else if (wr_en_i && wr_in_range) begin
      thr_q[wr_idx_i[IdxW-1:0]] <= wr_data_i;
    end
  end

  assign thr_o = thr_q[rd_idx_i];

endmodule

// ===== rtl/srhm_chan_state.sv =====
module srhm_chan_state
  import srhm_pkg::*;
#(
  parameter int unsigned CHANNELS = DefaultChannels
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  commit_i,
  input  in_item_t                              item_i,
  input  logic [DataW-1:0]                      thr_i,
  output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] idx_o,
  output out_item_t                             res_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [DataW-1:0] last_good_q [CHANNELS];
  logic [DataW-1:0] acc_val_q   [CHANNELS];
  logic             acc_flag_q  [CHANNELS];

  logic            in_range;
  logic [IdxW-1:0] idx;
  logic            flag;
  logic [DataW:0]  diff;
  logic [DataW:0]  mag;
  logic            below_thr;
  logic            good_take;
  logic            take_val;
  logic            new_flag;
  logic [DataW-1:0] new_val;

  assign in_range  = ({1'b0, item_i.channel} < (ChanW + 1)'(CHANNELS));
  assign idx       = item_i.channel[IdxW-1:0];
  assign idx_o     = idx;
  assign flag      = in_range && acc_flag_q[idx];
  assign good_take = in_range && item_i.sample_good;

  // 33-bit difference never overflows; its magnitude fits in 33 bits
  assign diff   = {item_i.sample[DataW-1], item_i.sample}
                - {last_good_q[idx][DataW-1], last_good_q[idx]};
  assign mag    = diff[DataW] ? (~diff + 1'b1) : diff;
  assign below_thr = (mag < {1'b0, thr_i});

  assign take_val = good_take && (!flag || below_thr);
  assign new_flag = flag || good_take;
  assign new_val  = take_val ? item_i.sample : acc_val_q[idx];

  always_comb begin
    res_o.out_channel    = item_i.channel;
    res_o.merged_good    = new_flag;
    res_o.merged_value   = new_flag ? new_val : '0;
    res_o.spike_rejected = good_take && flag && !below_thr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        acc_flag_q[i] <= 1'b0;
      end
    end else if (commit_i && good_take) begin
      acc_flag_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i && good_take) begin
      last_good_q[idx] <= item_i.sample;
    end
    if (commit_i && take_val) begin
      acc_val_q[idx] <= item_i.sample;
    end
  end

endmodule

// ===== rtl/spike_reject_hold_merge.sv =====
// Per-channel spike and gap filter for Q16.16 samples. Each input transaction
// carries a channel, a sample and a good flag and yields exactly one output
// transaction: the channel's accepted value and flag, plus whether this good
// sample was rejected as a jump larger than or equal to the channel's
// threshold (measured from the previous good raw sample). Missing samples
// leave the channel untouched; channels at or above CHANNELS report zeros.
// Throughput is one transaction per cycle while the output is not stalled; the
// path is an input register, then a combinational 33-bit subtract, abs and compare
// against the per-channel state held in flops, into the result register.
// Per-channel state updates as the item moves into the result register, so
// back-to-back samples on one channel see each other. Thresholds reset to
// all ones and should only be written while no transaction is in flight.
module spike_reject_hold_merge
  import srhm_pkg::*;
#(
  parameter int unsigned CHANNELS = DefaultChannels
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic      in_vld_q, in_vld_d;
  in_item_t  in_item_q;
  logic      out_vld_q, out_vld_d;
  out_item_t out_item_q;
  out_item_t res;
  logic      advance;
  logic [IdxW-1:0]  rd_idx;
  logic [DataW-1:0] thr;

  assign cfg_ready_o = 1'b1;

  srhm_thr_regs #(
    .CHANNELS (CHANNELS)
  ) u_thr_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .rd_idx_i  (rd_idx),
    .thr_o     (thr)
  );

  srhm_chan_state #(
    .CHANNELS (CHANNELS)
  ) u_chan_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (advance),
    .item_i   (in_item_q),
    .thr_i    (thr),
    .idx_o    (rd_idx),
    .res_o    (res)
  );

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_item_q;

`ifndef SYNTHESIS
  // a rejected spike always leaves an earlier accepted value in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_data_o.spike_rejected || out_data_o.merged_good))
    else $error("spike rejected on a channel with no accepted value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.merged_good) |-> (out_data_o.merged_value == '0))
    else $error("nonzero merged value without an accepted value");

  // stalled result with a full input register must back-pressure the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i && in_vld_q) |-> !in_ready_o)
    else $error("input accepted while pipeline is full and stalled");

  // a good sample that is not rejected shows up as the merged value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_item_q.sample_good && res.merged_good && !res.spike_rejected)
      |=> (out_data_o.merged_value == $past(in_item_q.sample)))
    else $error("accepted sample not reported as merged value");
`endif

endmodule
